// File: sv/bsr_pkg.sv
// Package for the Exp-Golomb bitstream reader: request/result structs, op codes,
// status codes, queue sizing and a 32-bit leading-zero count.
// No dependencies.
package bsr_pkg;

  localparam int unsigned BUF_BYTES_DEF = 256;
  localparam int unsigned REQ_W         = 3;
  localparam int unsigned BITCNT_W      = 12;
  localparam int unsigned VALUE_W       = 33;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned POS_W         = 12;

  // read window: offset within a byte plus the longest ue/se code (63 bits)
  localparam int unsigned WIN_BYTES     = 9;
  localparam int unsigned MAX_READ_BITS = 32;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);
  localparam int unsigned QCNTW  = $clog2(QDEPTH + 1);

  // request codes as they arrive on the port
  localparam logic [REQ_W-1:0] REQ_LOAD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SKIP    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_UE      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SE      = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RESTART = 3'd5;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_READ,
    OP_SKIP,
    OP_UE,
    OP_SE,
    OP_RESTART
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_OVERRUN,
    ST_BAD
  } status_e;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [7:0]          data_byte;
    logic [BITCNT_W-1:0] bit_count;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
    logic [POS_W-1:0]          position_after;
    logic                      overrun_seen;
  } res_t;

  // classified request as held in the queue
  typedef struct packed {
    op_e                 op;
    logic [7:0]          data_byte;
    logic [BITCNT_W-1:0] bit_count;
    logic                too_long;
  } q_entry_t;

  function automatic logic [5:0] lead_zeros32(input logic [31:0] w);
    logic [5:0] z;
    z = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (w[i]) begin
        z = 6'(31 - i);
      end
    end
    return z;
  endfunction

endpackage

// File: sv/bitstream_reader_exp_golomb.sv
// MSB-first bit reader with Exp-Golomb (ue/se) decoding over a byte buffer of
// BUF_BYTES entries. Requests arrive as valid/ready transfers on in_req_i and
// are decoded by a front end into a two-entry queue; the back end owns the byte
// store and read position and runs one request at a time, so the front keeps
// taking transfers while the back works. Load and restart requests give no
// result transfer; undefined request codes are accepted and dropped. Skip,
// and reads that fail or have zero length, complete without a byte fetch. A
// successful read of n bits fetches ceil((pos%8 + n)/8) bytes (at most 5);
// a ue/se decode fetches up to nine bytes from the position (fewer near the
// end of the loaded data). Bytes come through the single read port of the
// byte store, which delivers one byte a cycle. Results leave through an
// output register, so one finished result can wait while the next request
// starts. On a failed request the position moves to the end, the sticky
// overrun flag is set and the value is 0 (read/skip) or -1 (ue/se); status
// reports overrun or bad request (read above 32 bits, zero prefix above 31
// bits).
// Depends on bsr_pkg, bsr_front, bsr_fifo, bsr_back.
module bitstream_reader_exp_golomb import bsr_pkg::*; #(
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  // front -> queue
  logic     q_push, q_full;
  q_entry_t q_in;
  // queue -> back
  logic     q_valid, q_pop;
  q_entry_t q_head;

  bsr_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_in)
  );

  bsr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // back end: byte store, position, decode and result register
  bsr_back #(
    .BUF_BYTES (BUF_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

// File: sv/bsr_front.sv
// Front end: accepts request transfers, decodes the request code and drops
// undefined codes. Depends on bsr_pkg.
module bsr_front import bsr_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  req_t     in_req_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output q_entry_t q_entry_o
);

  logic legal;
  op_e  op;

  always_comb begin
    legal = 1'b1;
    op    = OP_LOAD;
    case (in_req_i.req_type)
      REQ_LOAD:    op = OP_LOAD;
      REQ_READ:    op = OP_READ;
      REQ_SKIP:    op = OP_SKIP;
      REQ_UE:      op = OP_UE;
      REQ_SE:      op = OP_SE;
      REQ_RESTART: op = OP_RESTART;
      default:     legal = 1'b0;
    endcase
  end

  assign in_ready_o = !q_full_i;
  // undefined codes are taken and discarded
  assign q_push_o   = in_valid_i && !q_full_i && legal;

  assign q_entry_o.op        = op;
  assign q_entry_o.data_byte = in_req_i.data_byte;
  assign q_entry_o.bit_count = in_req_i.bit_count;
  assign q_entry_o.too_long  = (in_req_i.bit_count > BITCNT_W'(MAX_READ_BITS));

endmodule

// File: sv/bsr_fifo.sv
// Short request queue between front and back end.
// Depends on bsr_pkg (entry type and depth).
module bsr_fifo import bsr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t head_o
);

  q_entry_t         ent_q [QDEPTH];
  logic [QPTRW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNTW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNTW'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTRW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTRW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: sv/bsr_back.sv
// Back end: byte store, read position, window fetch and bit extraction,
// Exp-Golomb decode and the result register. Depends on bsr_pkg.
module bsr_back import bsr_pkg::*; #(
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  q_entry_t q_entry_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output res_t     out_res_o
);

  localparam int unsigned CW = $clog2(BUF_BYTES + 1);
  localparam int unsigned AW = $clog2(BUF_BYTES);
  localparam int unsigned PW = CW + 3;
  localparam int unsigned WW = WIN_BYTES * 8;
  localparam int unsigned XW = PW + BITCNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_EXTR  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DEC   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          ovf_q, ovf_d;

  logic [PW-1:0] end_bits, left;
  logic [XW-1:0] left_x, n_x;

  // request context and datapath
  logic [CW-1:0]                base_q;
  logic [3:0]                   nb_q, nb_d, iss_q, rcv_q, widx;
  logic                         rdv_q;
  logic [2:0]                   off_q;
  logic [5:0]                   n_q, z_q, zc;
  op_e                          op_q;
  logic [WIN_BYTES-1:0][7:0]    win_q;
  logic [WW-1:0]                al_q, sh_q;

  logic [7:0]    mem_q [BUF_BYTES];
  logic [7:0]    rdata_q;
  logic          mem_we, rd_en, start;
  logic [CW:0]   raddr;
  logic [6:0]    rd_span;
  logic [CW-1:0] rem;

  logic          out_valid_q, out_free, emit;
  res_t          out_res_q, res_d;
  logic [POS_W+PW-1:0] pos_ext;

  logic [31:0] rd_val;
  logic [32:0] cp, ue_val, se_val;
  logic        zbad, zover;

  assign end_bits = {count_q, 3'b000};
  assign left     = end_bits - pos_q;
  assign left_x   = XW'(left);
  assign n_x      = XW'(q_entry_i.bit_count);
  assign out_free = !out_valid_q || out_ready_i;

  // fetch sizing
  assign rd_span = 7'(pos_q[2:0]) + 7'(q_entry_i.bit_count[5:0]) + 7'd7;
  assign rem     = count_q - pos_q[PW-1:3];
  assign raddr   = (CW+1)'(base_q) + (CW+1)'(iss_q);
  assign widx    = 4'(WIN_BYTES - 1) - rcv_q;

  // extraction
  assign rd_val = al_q[WW-1 -: 32] >> (6'd32 - n_q);
  assign zc     = lead_zeros32(al_q[WW-1 -: 32]);
  assign zbad   = (zc == 6'd32) && (left_x >= XW'(32));
  assign zover  = left_x < XW'({zc, 1'b1});
  assign cp     = sh_q[WW-1 -: 33] >> (6'd32 - z_q);
  assign ue_val = cp - 33'd1;
  assign se_val = cp[0] ? (33'd0 - {1'b0, cp[32:1]}) : {1'b0, cp[32:1]};

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    q_pop_o = 1'b0;
    emit    = 1'b0;
    mem_we  = 1'b0;
    rd_en   = 1'b0;
    start   = 1'b0;
    nb_d    = '0;
    res_d   = '0;
    pos_ext = '0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_entry_i.op)
            OP_LOAD: begin
              q_pop_o = 1'b1;
              if (count_q < CW'(BUF_BYTES)) begin
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            OP_RESTART: begin
              q_pop_o = 1'b1;
              count_d = '0;
              pos_d   = '0;
              ovf_d   = 1'b0;
            end
            OP_READ: begin
              if (q_entry_i.too_long || (left_x < n_x) || (q_entry_i.bit_count == '0)) begin
                if (out_free) begin
                  q_pop_o = 1'b1;
                  emit    = 1'b1;
                  if (q_entry_i.too_long) begin
                    res_d.status = ST_BAD;
                    pos_d        = end_bits;
                    ovf_d        = 1'b1;
                  end else if (left_x < n_x) begin
                    res_d.status = ST_OVERRUN;
                    pos_d        = end_bits;
                    ovf_d        = 1'b1;
                  end
                end
              end else begin
                q_pop_o = 1'b1;
                start   = 1'b1;
                nb_d    = rd_span[6:3];
                state_d = S_FETCH;
              end
            end
            OP_SKIP: begin
              if (out_free) begin
                q_pop_o = 1'b1;
                emit    = 1'b1;
                if (left_x < n_x) begin
                  res_d.status = ST_OVERRUN;
                  pos_d        = end_bits;
                  ovf_d        = 1'b1;
                end else begin
                  pos_d = PW'(XW'(pos_q) + n_x);
                end
              end
            end
            OP_UE, OP_SE: begin
              q_pop_o = 1'b1;
              start   = 1'b1;
              nb_d    = (rem > CW'(WIN_BYTES)) ? 4'(WIN_BYTES) : rem[3:0];
              state_d = S_FETCH;
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      S_FETCH: begin
        rd_en = (iss_q < nb_q);
        if (rcv_q == nb_q) begin
          state_d = S_ALIGN;
        end
      end
      S_ALIGN: state_d = S_EXTR;
      S_EXTR: begin
        if (op_q == OP_READ) begin
          if (out_free) begin
            emit        = 1'b1;
            res_d.value = {1'b0, rd_val};
            pos_d       = pos_q + PW'(n_q);
            state_d     = S_IDLE;
          end
        end else if (zbad || zover) begin
          if (out_free) begin
            emit         = 1'b1;
            res_d.value  = '1;
            res_d.status = zbad ? ST_BAD : ST_OVERRUN;
            pos_d        = end_bits;
            ovf_d        = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: state_d = S_DEC;
      S_DEC: begin
        if (out_free) begin
          emit        = 1'b1;
          res_d.value = (op_q == OP_UE) ? ue_val : se_val;
          pos_d       = pos_q + PW'({z_q, 1'b1});
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    pos_ext              = {{POS_W{1'b0}}, pos_d};
    res_d.position_after = pos_ext[POS_W-1:0];
    res_d.overrun_seen   = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      iss_q       <= '0;
      rcv_q       <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
      rdv_q   <= rd_en;
      if (start) begin
        iss_q <= '0;
        rcv_q <= '0;
      end else begin
        if (rd_en) begin
          iss_q <= iss_q + 1'b1;
        end
        if (rdv_q) begin
          rcv_q <= rcv_q + 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      base_q <= pos_q[PW-1:3];
      off_q  <= pos_q[2:0];
      n_q    <= q_entry_i.bit_count[5:0];
      op_q   <= q_entry_i.op;
      nb_q   <= nb_d;
      win_q  <= '0;
    end else if (rdv_q) begin
      win_q[widx] <= rdata_q;
    end
    if (state_q == S_ALIGN) begin
      al_q <= win_q << off_q;
    end
    if (state_q == S_EXTR) begin
      z_q <= zc;
    end
    if (state_q == S_SHIFT) begin
      sh_q <= al_q << z_q;
    end
    if (emit) begin
      out_res_q <= res_d;
    end
  end

  // byte store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[AW-1:0]] <= q_entry_i.data_byte;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr[AW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= end_bits)
    else $error("read position beyond loaded bits");

  a_fetch_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |-> (iss_q <= nb_q) && (rcv_q <= iss_q) && (nb_q <= 4'(WIN_BYTES)))
    else $error("window fetch counters out of step");

  a_flag_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(ovf_q) |-> $past(q_pop_o && q_entry_i.op == OP_RESTART))
    else $error("overrun flag cleared without restart");

endmodule
